// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define IIBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define IIBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/iibb_pkg.sv
// ----------------------------------------------------------------------------
// iibb_pkg
// Shared constants and types for the integral image box blur.
// ----------------------------------------------------------------------------
package iibb_pkg;

    // Default size limits and filter radius.
    localparam int DEF_RADIUS     = 7;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths.
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

    // Register index, taken from paddr bit 2.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } iibb_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic row_init;
        logic gather;
        logic col_init;
        logic sum_step;
        logic div_step;
        logic emit;
    } iibb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_emit;
        logic gather_last;
        logic sum_last;
        logic div_last;
        logic out_free;
        logic col_last;
        logic row_last;
    } iibb_status_t;

endpackage

// File: rtl/integral_image_box_blur.sv
// ----------------------------------------------------------------------------
// integral_image_box_blur
// Box blur of a three-channel raster stream using line and column sums.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  input     in_valid / in_ready       in_ch0, in_ch1, in_ch2
//  output    out_valid / out_ready     out_row, out_col, out_ch0..2, run_last
//  config    APB psel/penable/pwrite   paddr, pwdata, prdata (pready high)
//
// A pixel that yields no result is only written to the line store. For
// each output row of a pixel, the block sets up the row, reads up to 15x15
// line store entries (one read per cycle) into column sums and drains the
// read port; each result then takes a column setup, a window sum, a divide
// over the dividend bits (16 at radius 7) and an emit step. A stalled output
// only holds the emit step. The line store needs no clearing after reset.
module integral_image_box_blur #(
    parameter int RADIUS     = iibb_pkg::DEF_RADIUS,
    parameter int MAX_WIDTH  = iibb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iibb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [iibb_pkg::PIX_W-1:0]         in_ch0,
    input  logic [iibb_pkg::PIX_W-1:0]         in_ch1,
    input  logic [iibb_pkg::PIX_W-1:0]         in_ch2,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [$clog2(MAX_HEIGHT)-1:0]      out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]       out_col,
    output logic [iibb_pkg::PIX_W-1:0]         out_ch0,
    output logic [iibb_pkg::PIX_W-1:0]         out_ch1,
    output logic [iibb_pkg::PIX_W-1:0]         out_ch2,
    output logic                               run_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [iibb_pkg::APB_AW-1:0]        paddr,
    input  logic [iibb_pkg::APB_DW-1:0]        pwdata,
    output logic [iibb_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import iibb_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int LW = $clog2(2 * RADIUS + 2);
    localparam int AW = LW + XW;

    logic [CFG_W-1:0]   frame_width;
    logic [CFG_W-1:0]   frame_height;
    logic               restart;
    iibb_cmd_t          cmd;
    iibb_status_t       status;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [3*PIX_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [3*PIX_W-1:0] mem_rdata;

    // Configuration registers.
    iibb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .restart      (restart)
    );

    // Sequencer.
    iibb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Line store of the last 2*RADIUS+2 rows.
    iibb_line_mem #(
        .AW (AW),
        .DW (3 * PIX_W)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Arithmetic and result register.
    iibb_datapath #(
        .RADIUS     (RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XW         (XW),
        .YW         (YW),
        .LW         (LW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .restart      (restart),
        .in_ch0       (in_ch0),
        .in_ch1       (in_ch1),
        .in_ch2       (in_ch2),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_ch0      (out_ch0),
        .out_ch1      (out_ch1),
        .out_ch2      (out_ch2),
        .run_last     (run_last)
    );

endmodule

// File: rtl/iibb_regs.sv
// ----------------------------------------------------------------------------
// iibb_regs
// APB register file holding the frame size; any write restarts the frame.
// ----------------------------------------------------------------------------
module iibb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iibb_pkg::APB_AW-1:0]  paddr,
    input  logic [iibb_pkg::APB_DW-1:0]  pwdata,
    output logic [iibb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [iibb_pkg::CFG_W-1:0]   frame_width,
    output logic [iibb_pkg::CFG_W-1:0]   frame_height,
    output logic                         restart
);
    import iibb_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             wr_en;
    iibb_reg_t        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = iibb_reg_t'(paddr[2]);
    assign restart = wr_en;

    // Register writes on the access cycle of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DW'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign frame_width  = width_reg;
    assign frame_height = height_reg;

endmodule

// File: rtl/iibb_line_mem.sv
// ----------------------------------------------------------------------------
// iibb_line_mem
// Single-port-write, single-port-read line store with registered read data.
// ----------------------------------------------------------------------------
module iibb_line_mem #(
    parameter int AW = 14,
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] ram_reg [2**AW];
    logic [DW-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/iibb_datapath.sv
// ----------------------------------------------------------------------------
// iibb_datapath
// Raster position, column sums, window sums, divider and result register.
// ----------------------------------------------------------------------------
module iibb_datapath #(
    parameter int RADIUS     = iibb_pkg::DEF_RADIUS,
    parameter int MAX_WIDTH  = iibb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iibb_pkg::DEF_MAX_HEIGHT,
    parameter int XW         = $clog2(MAX_WIDTH),
    parameter int YW         = $clog2(MAX_HEIGHT),
    parameter int LW         = $clog2(2 * RADIUS + 2)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iibb_pkg::iibb_cmd_t           cmd,
    output iibb_pkg::iibb_status_t        status,
    input  logic [iibb_pkg::CFG_W-1:0]    frame_width,
    input  logic [iibb_pkg::CFG_W-1:0]    frame_height,
    input  logic                          restart,
    input  logic [iibb_pkg::PIX_W-1:0]    in_ch0,
    input  logic [iibb_pkg::PIX_W-1:0]    in_ch1,
    input  logic [iibb_pkg::PIX_W-1:0]    in_ch2,
    output logic                          mem_we,
    output logic [LW+XW-1:0]              mem_waddr,
    output logic [3*iibb_pkg::PIX_W-1:0]  mem_wdata,
    output logic [LW+XW-1:0]              mem_raddr,
    input  logic [3*iibb_pkg::PIX_W-1:0]  mem_rdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [YW-1:0]                 out_row,
    output logic [XW-1:0]                 out_col,
    output logic [iibb_pkg::PIX_W-1:0]    out_ch0,
    output logic [iibb_pkg::PIX_W-1:0]    out_ch1,
    output logic [iibb_pkg::PIX_W-1:0]    out_ch2,
    output logic                          run_last
);
    import iibb_pkg::*;

    localparam int LC    = 2 * RADIUS + 2;
    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int LIW   = $clog2(SPAN);
    localparam int NSW   = $clog2(SPAN + 1);
    localparam int NUMW  = 2 * NSW;
    localparam int CSW   = $clog2(SPAN * 255 + 1);
    localparam int SUMW  = $clog2(SPAN * SPAN * 255 + 1);
    localparam int DCW   = $clog2(SUMW);
    localparam int WSW   = XW + 1;
    localparam int HSW   = YW + 1;
    localparam int WCW   = (WSW > CFG_W) ? WSW : CFG_W;
    localparam int HCW   = (HSW > CFG_W) ? HSW : CFG_W;

    // Edge helpers: first row/column below the box and last one inside it.
    function automatic logic [XW-1:0] lo_x(input logic [XW-1:0] p);
        lo_x = (p >= XW'(RADIUS + 1)) ? p - XW'(RADIUS + 1) : '0;
    endfunction

    function automatic logic [XW-1:0] hi_x(input logic [XW-1:0] p,
                                           input logic [WSW-1:0] size);
        logic [WSW-1:0] t;
        t = {1'b0, p} + WSW'(RADIUS);
        hi_x = (t >= size) ? XW'(size - WSW'(1)) : XW'(t);
    endfunction

    function automatic logic [YW-1:0] lo_y(input logic [YW-1:0] p);
        lo_y = (p >= YW'(RADIUS + 1)) ? p - YW'(RADIUS + 1) : '0;
    endfunction

    function automatic logic [YW-1:0] hi_y(input logic [YW-1:0] p,
                                           input logic [HSW-1:0] size);
        logic [HSW-1:0] t;
        t = {1'b0, p} + HSW'(RADIUS);
        hi_y = (t >= size) ? YW'(size - HSW'(1)) : YW'(t);
    endfunction

    // Effective frame size, clamped to 2..MAX.
    logic [WCW-1:0] fw_ext;
    logic [HCW-1:0] fh_ext;
    logic [WSW-1:0] w_eff;
    logic [HSW-1:0] h_eff;

    always_comb
    begin
        fw_ext = WCW'(frame_width);
        fh_ext = HCW'(frame_height);
        if (fw_ext < WCW'(2))
            w_eff = WSW'(2);
        else if (fw_ext > WCW'(MAX_WIDTH))
            w_eff = WSW'(MAX_WIDTH);
        else
            w_eff = WSW'(fw_ext);
        if (fh_ext < HCW'(2))
            h_eff = HSW'(2);
        else if (fh_ext > HCW'(MAX_HEIGHT))
            h_eff = HSW'(MAX_HEIGHT);
        else
            h_eff = HSW'(fh_ext);
    end

    // Raster position of the next pixel and its line slot.
    logic [YW-1:0] row_reg;
    logic [XW-1:0] col_reg;
    logic [LW-1:0] line_reg;
    logic          pos_bad;
    logic [YW-1:0] eff_row;
    logic [XW-1:0] eff_col;
    logic [LW-1:0] eff_line;
    logic          last_row;
    logic          last_col;
    logic          rows_ok;
    logic          cols_ok;
    logic [YW-1:0] rlo;
    logic [YW-1:0] rhi;
    logic [XW-1:0] clo;
    logic [XW-1:0] chi;

    always_comb
    begin
        pos_bad  = ({1'b0, row_reg} >= h_eff) || ({1'b0, col_reg} >= w_eff);
        eff_row  = pos_bad ? '0 : row_reg;
        eff_col  = pos_bad ? '0 : col_reg;
        eff_line = pos_bad ? '0 : line_reg;
        last_row = ({1'b0, eff_row} == h_eff - HSW'(1));
        last_col = ({1'b0, eff_col} == w_eff - WSW'(1));
        rows_ok  = last_row || (eff_row >= YW'(RADIUS));
        cols_ok  = last_col || (eff_col >= XW'(RADIUS));
        rlo      = (eff_row >= YW'(RADIUS)) ? eff_row - YW'(RADIUS) : '0;
        rhi      = last_row ? eff_row : rlo;
        clo      = (eff_col >= XW'(RADIUS)) ? eff_col - XW'(RADIUS) : '0;
        chi      = last_col ? eff_col : clo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (restart)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                if (last_row)
                begin
                    row_reg  <= '0;
                    line_reg <= '0;
                end
                else
                begin
                    row_reg  <= eff_row + YW'(1);
                    line_reg <= (eff_line == LW'(LC - 1)) ? '0 : eff_line + LW'(1);
                end
            end
            else
            begin
                col_reg <= eff_col + XW'(1);
            end
        end
    end

    // Line store write of the accepted pixel.
    assign mem_we    = cmd.accept;
    assign mem_waddr = {eff_line, eff_col};
    assign mem_wdata = {in_ch2, in_ch1, in_ch0};

    // Step bounds latched on acceptance.
    logic [YW-1:0] y_reg;
    logic [LW-1:0] yline_reg;
    logic [YW-1:0] r_reg;
    logic [YW-1:0] rhi_reg;
    logic [XW-1:0] c_reg;
    logic [XW-1:0] clo_reg;
    logic [XW-1:0] chi_reg;

    // Row setup values.
    logic [YW-1:0]  y1;
    logic [YW-1:0]  y2;
    logic [YW-1:0]  ydist;
    logic [LW-1:0]  dline;
    logic [LW:0]    wrap_line;
    logic [LW-1:0]  sline;
    logic [XW-1:0]  xa;

    always_comb
    begin
        y1        = lo_y(r_reg);
        y2        = hi_y(r_reg, h_eff);
        ydist     = y_reg - (y1 + YW'(1));
        dline     = LW'(ydist);
        wrap_line = {1'b0, yline_reg} + (LW + 1)'(LC) - {1'b0, dline};
        sline     = (yline_reg >= dline) ? yline_reg - dline : LW'(wrap_line);
        xa        = lo_x(clo_reg) + XW'(1);
    end

    // Gather counters.
    logic [LW-1:0]  gline_reg;
    logic [LW-1:0]  gline0_reg;
    logic [NSW-1:0] gy_reg;
    logic [NSW-1:0] ny_reg;
    logic [XW-1:0]  gx_reg;
    logic [XW-1:0]  xa_reg;
    logic [XW-1:0]  xb_reg;
    logic [LIW-1:0] gidx_reg;
    logic           gy_last;

    assign gy_last   = (gy_reg == ny_reg - NSW'(1));
    assign mem_raddr = {gline_reg, gx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            y_reg     <= eff_row;
            yline_reg <= eff_line;
            r_reg     <= rlo;
            rhi_reg   <= rhi;
            c_reg     <= clo;
            clo_reg   <= clo;
            chi_reg   <= chi;
        end
        else if (cmd.emit)
        begin
            if (c_reg == chi_reg)
            begin
                r_reg <= r_reg + YW'(1);
                c_reg <= clo_reg;
            end
            else
            begin
                c_reg <= c_reg + XW'(1);
            end
        end
        if (cmd.row_init)
        begin
            gline_reg  <= sline;
            gline0_reg <= sline;
            gy_reg     <= '0;
            ny_reg     <= NSW'(y2 - y1);
            gx_reg     <= xa;
            xa_reg     <= xa;
            xb_reg     <= hi_x(chi_reg, w_eff);
            gidx_reg   <= '0;
        end
        else if (cmd.gather)
        begin
            if (gy_last)
            begin
                gy_reg    <= '0;
                gline_reg <= gline0_reg;
                gx_reg    <= gx_reg + XW'(1);
                gidx_reg  <= gidx_reg + LIW'(1);
            end
            else
            begin
                gy_reg    <= gy_reg + NSW'(1);
                gline_reg <= (gline_reg == LW'(LC - 1)) ? '0 : gline_reg + LW'(1);
            end
        end
    end

    // Read pipeline tags, registered in step with the line store read data.
    logic           p_valid_reg;
    logic           p_first_reg;
    logic           p_last_reg;
    logic [LIW-1:0] p_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= cmd.gather;
    end

    always_ff @(posedge clk)
    begin
        p_first_reg <= (gy_reg == '0);
        p_last_reg  <= gy_last;
        p_idx_reg   <= gidx_reg;
    end

    // Vertical column sums per channel.
    logic [2:0][CSW-1:0] cacc_reg;
    logic [2:0][CSW-1:0] cacc_next;
    logic [2:0][CSW-1:0] colsum_reg [SPAN];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cacc_next[k] = (p_first_reg ? CSW'(0) : cacc_reg[k])
                         + CSW'(mem_rdata[k*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            cacc_reg <= cacc_next;
            if (p_last_reg)
                colsum_reg[p_idx_reg] <= cacc_next;
        end
    end

    // Window setup and horizontal sum.
    logic [XW-1:0]        x1;
    logic [XW-1:0]        x2;
    logic [LIW-1:0]       sidx_reg;
    logic [LIW-1:0]       send_reg;
    logic [NUMW-1:0]      num_reg;
    logic [2:0][SUMW-1:0] sum_reg;
    logic [2:0][SUMW-1:0] sum_next;

    always_comb
    begin
        x1 = lo_x(c_reg);
        x2 = hi_x(c_reg, w_eff);
        for (int k = 0; k < 3; k++)
            sum_next[k] = sum_reg[k] + SUMW'(colsum_reg[sidx_reg][k]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.col_init)
        begin
            sidx_reg <= LIW'(x1 + XW'(1) - xa_reg);
            send_reg <= LIW'(x2 - xa_reg);
            num_reg  <= NUMW'(NUMW'(NSW'(x2 - x1)) * NUMW'(ny_reg));
            sum_reg  <= '0;
        end
        else if (cmd.sum_step)
        begin
            sidx_reg <= sidx_reg + LIW'(1);
            sum_reg  <= sum_next;
        end
    end

    // Restoring divider, one quotient bit per cycle for all channels.
    logic [2:0][SUMW-1:0] dq_reg;
    logic [2:0][NUMW-1:0] drem_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic [2:0][NUMW:0]   dshift;
    logic [2:0]           dfit;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dshift[k] = {drem_reg[k], dq_reg[k][SUMW-1]};
            dfit[k]   = (dshift[k] >= {1'b0, num_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_step && status.sum_last)
        begin
            dq_reg   <= sum_next;
            drem_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                drem_reg[k] <= dfit[k] ? NUMW'(dshift[k] - {1'b0, num_reg})
                                       : NUMW'(dshift[k]);
                dq_reg[k]   <= {dq_reg[k][SUMW-2:0], dfit[k]};
            end
            dcnt_reg <= dcnt_reg + DCW'(1);
        end
    end

    // Result register.
    logic              out_valid_reg;
    logic [YW-1:0]     out_row_reg;
    logic [XW-1:0]     out_col_reg;
    logic [2:0][PIX_W-1:0] out_ch_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg  <= r_reg;
            out_col_reg  <= c_reg;
            for (int k = 0; k < 3; k++)
                out_ch_reg[k] <= dq_reg[k][PIX_W-1:0];
            out_last_reg <= (r_reg == rhi_reg) && (c_reg == chi_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_ch0   = out_ch_reg[0];
    assign out_ch1   = out_ch_reg[1];
    assign out_ch2   = out_ch_reg[2];
    assign run_last  = out_last_reg;

    // Status to the controller.
    always_comb
    begin
        status.step_emit   = rows_ok && cols_ok;
        status.gather_last = gy_last && (gx_reg == xb_reg);
        status.sum_last    = (sidx_reg == send_reg);
        status.div_last    = (dcnt_reg == DCW'(SUMW - 1));
        status.out_free    = !out_valid_reg || out_ready;
        status.col_last    = (c_reg == chi_reg);
        status.row_last    = (r_reg == rhi_reg);
    end

endmodule

// File: rtl/iibb_ctrl.sv
// ----------------------------------------------------------------------------
// iibb_ctrl
// Sequencer for one pixel: row setup, gather, window sum, divide, emit.
// ----------------------------------------------------------------------------
module iibb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  iibb_pkg::iibb_status_t status,
    output iibb_pkg::iibb_cmd_t    cmd
);
    import iibb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ROW    = 8'b0000_0010,
        ST_GATHER = 8'b0000_0100,
        ST_DRAIN  = 8'b0000_1000,
        ST_COL    = 8'b0001_0000,
        ST_SUM    = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.step_emit)
                        state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                cmd.row_init = 1'b1;
                state_next   = ST_GATHER;
            end
            ST_GATHER:
            begin
                cmd.gather = 1'b1;
                if (status.gather_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_COL;
            end
            ST_COL:
            begin
                cmd.col_init = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_last)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!status.col_last)
                        state_next = ST_COL;
                    else if (status.row_last)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/iibb_checker.sv
// ----------------------------------------------------------------------------
// iibb_checker
// Port-level checks of the box blur, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iibb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [iibb_pkg::PIX_W-1:0]      out_ch0,
    input logic                            run_last
);
    import iibb_pkg::*;

    // While a result that is not the last of its pixel waits, the pixel is still in work.
    `IIBB_ASSERT(a_busy_mid_step, (out_valid && !run_last) |-> !in_ready, "input ready mid-step")

    // Once the last result is taken while idle, no result follows at once.
    `IIBB_ASSERT_NEXT(a_quiet_after_last, out_valid && out_ready && run_last && in_ready, !out_valid, "result without a new pixel")

    // A stalled result stays valid with out_ch0 and run_last unchanged.
    `IIBB_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_ch0) && $stable(run_last), "stalled result changed")

endmodule

bind integral_image_box_blur iibb_checker u_iibb_checker (.*);
